// ----- src/mls_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mls_pkg: shared types and constants of the load/store unit
// Holds the data region bounds, the command codes and the beat structs that
// move between the decode, storage and result formatting parts.
// ----------------------------------------------------------------------------
package mls_pkg;

    // Data region: byte address base and size
    localparam logic [31:0] DATA_BASE  = 32'h2000_0000;
    localparam int unsigned DATA_BYTES = 65536;
    localparam int unsigned DATA_WORDS = DATA_BYTES / 4;
    localparam int unsigned WORD_AW    = $clog2(DATA_WORDS);

    // Region end, clipped to the 32-bit address space
    localparam logic [32:0] DATA_END_RAW = {1'b0, DATA_BASE} + 33'(DATA_BYTES);
    localparam logic [32:0] DATA_END     = (DATA_END_RAW > 33'h1_0000_0000) ?
                                           33'h1_0000_0000 : DATA_END_RAW;

    // Command codes
    localparam logic [3:0] CMD_LB  = 4'd0;
    localparam logic [3:0] CMD_LBU = 4'd1;
    localparam logic [3:0] CMD_LH  = 4'd2;
    localparam logic [3:0] CMD_LHU = 4'd3;
    localparam logic [3:0] CMD_LW  = 4'd4;
    localparam logic [3:0] CMD_LWL = 4'd5;
    localparam logic [3:0] CMD_LWR = 4'd6;
    localparam logic [3:0] CMD_SB  = 4'd7;
    localparam logic [3:0] CMD_SH  = 4'd8;
    localparam logic [3:0] CMD_SW  = 4'd9;

    typedef logic [WORD_AW-1:0] word_index_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] address;
        logic [31:0] operand_value;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        status;
    } out_beat_t;

    // Control carried from decode to result formatting
    typedef struct packed {
        logic [3:0]  cmd;
        logic [1:0]  offset;
        logic        ok;
        logic [31:0] operand_value;
    } acc_ctl_t;

    // Full decoded access: control plus the storage request
    typedef struct packed {
        acc_ctl_t    ctl;
        logic        wr_en;
        logic [3:0]  be;
        logic [31:0] wr_data;
        word_index_t index;
    } acc_t;

endpackage : mls_pkg
`default_nettype wire

// ----- src/mls_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mls_decode: access decode
// Checks alignment and region, and builds the word index, byte enables and
// lane-replicated store data for one input beat.
// ----------------------------------------------------------------------------
module mls_decode
    import mls_pkg::*;
(
    input  wire in_beat_t beat,
    output acc_t          acc
);

    logic [32:0] word_lo;
    logic [32:0] word_hi;
    logic [31:0] rel;
    logic        in_region;
    logic        legal;
    logic        is_store;
    logic [1:0]  offset;

    // Every access stays within one aligned word, so check the whole word
    always_comb begin
        offset    = beat.address[1:0];
        word_lo   = {1'b0, beat.address[31:2], 2'b00};
        word_hi   = word_lo + 33'd3;
        in_region = (word_lo >= {1'b0, DATA_BASE}) && (word_hi < DATA_END);
        rel       = beat.address - DATA_BASE;
        is_store  = beat.cmd inside {CMD_SB, CMD_SH, CMD_SW};
    end

    // Alignment rules per command; unknown codes are illegal
    always_comb begin
        case (beat.cmd)
            CMD_LB, CMD_LBU, CMD_LWL, CMD_LWR, CMD_SB: legal = 1'b1;
            CMD_LH, CMD_LHU, CMD_SH:                   legal = ~offset[0];
            CMD_LW, CMD_SW:                            legal = (offset == 2'b00);
            default:                                   legal = 1'b0;
        endcase
    end

    // Byte enables and store lanes, byte 0 in bits 31:24
    always_comb begin
        acc.ctl.cmd           = beat.cmd;
        acc.ctl.offset        = offset;
        acc.ctl.ok            = legal & in_region;
        acc.ctl.operand_value = beat.operand_value;
        acc.index             = rel[WORD_AW+1:2];
        acc.wr_en             = legal & in_region & is_store;
        case (beat.cmd)
            CMD_SB: begin
                acc.be      = 4'b1000 >> offset;
                acc.wr_data = {4{beat.operand_value[7:0]}};
            end
            CMD_SH: begin
                acc.be      = offset[1] ? 4'b0011 : 4'b1100;
                acc.wr_data = {2{beat.operand_value[15:0]}};
            end
            CMD_SW: begin
                acc.be      = 4'b1111;
                acc.wr_data = beat.operand_value;
            end
            default: begin
                acc.be      = 4'b0000;
                acc.wr_data = beat.operand_value;
            end
        endcase
    end

endmodule : mls_decode
`default_nettype wire

// ----- src/mls_data_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mls_data_ram: data store
// Word-wide memory with byte write enables and a registered read port.
// ----------------------------------------------------------------------------
module mls_data_ram
    import mls_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        wr_en,
    input  wire word_index_t wr_index,
    input  wire logic [3:0]  wr_be,
    input  wire logic [31:0] wr_data,
    input  wire logic        rd_en,
    input  wire word_index_t rd_index,
    output logic [31:0]      rd_data
);

    logic [31:0] mem [DATA_WORDS];
    logic [31:0] rd_data_reg;

    // Write enabled byte lanes
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int b = 0; b < 4; b++) begin
                if (wr_be[b]) begin
                    mem[wr_index][8*b +: 8] <= wr_data[8*b +: 8];
                end
            end
        end
    end

    // Read and hold until the next enabled read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_index];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : mls_data_ram
`default_nettype wire

// ----- src/mls_format.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mls_format: result formatting
// Selects, extends or merges the bytes of the read word into the result beat.
// ----------------------------------------------------------------------------
module mls_format
    import mls_pkg::*;
(
    input  wire acc_ctl_t     ctl,
    input  wire logic [31:0]  word,
    output out_beat_t         beat
);

    logic [7:0]  byte_sel;
    logic [15:0] half_sel;
    logic [31:0] lwl_val;
    logic [31:0] lwr_val;
    logic [31:0] res;
    logic [31:0] v;

    // Pick the addressed byte and halfword
    always_comb begin
        v        = ctl.operand_value;
        half_sel = ctl.offset[1] ? word[15:0] : word[31:16];
        case (ctl.offset)
            2'd0:    byte_sel = word[31:24];
            2'd1:    byte_sel = word[23:16];
            2'd2:    byte_sel = word[15:8];
            default: byte_sel = word[7:0];
        endcase
    end

    // Merge for the unaligned word loads
    always_comb begin
        case (ctl.offset)
            2'd0: begin
                lwl_val = word;
                lwr_val = {v[31:8], word[31:24]};
            end
            2'd1: begin
                lwl_val = {word[23:0], v[7:0]};
                lwr_val = {v[31:16], word[31:16]};
            end
            2'd2: begin
                lwl_val = {word[15:0], v[15:0]};
                lwr_val = {v[31:24], word[31:8]};
            end
            default: begin
                lwl_val = {word[7:0], v[23:0]};
                lwr_val = word;
            end
        endcase
    end

    // Final value; stores and errors return zero
    always_comb begin
        case (ctl.cmd)
            CMD_LB:  res = {{24{byte_sel[7]}}, byte_sel};
            CMD_LBU: res = {24'd0, byte_sel};
            CMD_LH:  res = {{16{half_sel[15]}}, half_sel};
            CMD_LHU: res = {16'd0, half_sel};
            CMD_LW:  res = word;
            CMD_LWL: res = lwl_val;
            CMD_LWR: res = lwr_val;
            default: res = 32'd0;
        endcase
        beat.read_data = ctl.ok ? res : 32'd0;
        beat.status    = ~ctl.ok;
    end

endmodule : mls_format
`default_nettype wire

// ----- src/mips_load_store_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mips_load_store_unit: big-endian data memory access unit
// Three-stage pipe: decode register, memory read register, result register.
//
//   Channel  Ports                       Payload
//   input    s_valid, s_ready, s_data    in_beat_t  (cmd, address, operand)
//   result   m_valid, m_ready, m_data    out_beat_t (read_data, status)
//
// One beat per cycle sustained while the result side is ready; a result
// passes the decode, memory read and result registers in turn, the middle
// stage set by the registered word read. After reset a clearing pass zeroes
// all DATA_WORDS (16384) store words, one per cycle, with s_ready held low.
// Each stage holds its beat while the next one is full and stalled, so
// empty stages still take new beats when the result side stalls.
// ----------------------------------------------------------------------------
module mips_load_store_unit
    import mls_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_beat_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_beat_t     m_data
);

    acc_t        dec_acc;
    acc_t        a_acc_reg;
    acc_t        a_acc_next;
    logic        a_valid_reg;
    logic        a_valid_next;
    acc_ctl_t    b_ctl_reg;
    acc_ctl_t    b_ctl_next;
    logic        b_valid_reg;
    logic        b_valid_next;
    out_beat_t   out_beat_reg;
    out_beat_t   out_beat_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_beat_t   fmt_beat;
    logic        clear_reg;
    logic        clear_next;
    word_index_t clear_idx_reg;
    word_index_t clear_idx_next;

    logic        a_ready;
    logic        b_ready;
    logic        c_ready;
    logic        adv_a;
    logic        adv_b;
    logic        s_take;

    logic        ram_wr_en;
    word_index_t ram_wr_index;
    logic [3:0]  ram_wr_be;
    logic [31:0] ram_wr_data;
    logic [31:0] ram_rd_data;

    mls_decode u_decode (
        .beat (s_data),
        .acc  (dec_acc)
    );

    // Stage handshakes: a stage loads when empty or when it drains
    always_comb begin
        c_ready = ~out_valid_reg | m_ready;
        b_ready = ~b_valid_reg | c_ready;
        a_ready = ~a_valid_reg | b_ready;
        adv_a   = a_valid_reg & b_ready;
        adv_b   = b_valid_reg & c_ready;
        s_ready = a_ready & ~clear_reg;
        s_take  = s_valid & s_ready;
    end

    // Store port: clearing pass first, then decoded stores
    always_comb begin
        if (clear_reg) begin
            ram_wr_en    = 1'b1;
            ram_wr_index = clear_idx_reg;
            ram_wr_be    = 4'b1111;
            ram_wr_data  = 32'd0;
        end else begin
            ram_wr_en    = adv_a & a_acc_reg.wr_en;
            ram_wr_index = a_acc_reg.index;
            ram_wr_be    = a_acc_reg.be;
            ram_wr_data  = a_acc_reg.wr_data;
        end
    end

    mls_data_ram u_ram (
        .aclk     (aclk),
        .wr_en    (ram_wr_en),
        .wr_index (ram_wr_index),
        .wr_be    (ram_wr_be),
        .wr_data  (ram_wr_data),
        .rd_en    (adv_a),
        .rd_index (a_acc_reg.index),
        .rd_data  (ram_rd_data)
    );

    mls_format u_format (
        .ctl  (b_ctl_reg),
        .word (ram_rd_data),
        .beat (fmt_beat)
    );

    // Next values: advance each stage, drop valid when drained
    always_comb begin
        a_valid_next   = s_take | (a_valid_reg & ~b_ready);
        a_acc_next     = s_take ? dec_acc : a_acc_reg;
        b_valid_next   = adv_a | (b_valid_reg & ~c_ready);
        b_ctl_next     = adv_a ? a_acc_reg.ctl : b_ctl_reg;
        out_valid_next = adv_b | (out_valid_reg & ~m_ready);
        out_beat_next  = adv_b ? fmt_beat : out_beat_reg;
        clear_idx_next = clear_reg ? clear_idx_reg + 1'b1 : clear_idx_reg;
        clear_next     = clear_reg & (clear_idx_reg != {WORD_AW{1'b1}});
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            clear_reg     <= 1'b1;
            clear_idx_reg <= '0;
        end else begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            clear_reg     <= clear_next;
            clear_idx_reg <= clear_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        a_acc_reg    <= a_acc_next;
        b_ctl_reg    <= b_ctl_next;
        out_beat_reg <= out_beat_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_beat_reg;

    // The store is cleared before any beat is taken
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_reg |-> (!s_ready && !a_valid_reg && !b_valid_reg))
        else $error("beat in flight during clearing pass");

    // Reset starts a clearing pass
    a_reset_starts_clear: assert property (@(posedge aclk)
        !aresetn |=> clear_reg)
        else $error("clearing pass not started after reset");

    // Error results carry zero data
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status) |-> (m_data.read_data == 32'd0))
        else $error("error result with nonzero data");

    // Only legal, in-region stores reach the store port outside clearing
    a_write_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && !clear_reg) |-> (a_valid_reg && a_acc_reg.ctl.ok))
        else $error("store write without a legal access");

endmodule : mips_load_store_unit
`default_nettype wire

// ----- tb/tb_mips_load_store_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_mips_load_store_unit: self-checking bench for the big-endian load/store unit
// Feeds directed and random load/store beats through the valid/ready input
// channel and checks every result beat against a local model of the data
// store. Both channels idle in random bursts, except in the final stretch.
// ----------------------------------------------------------------------------
module tb_mips_load_store_unit;
    import mls_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_ITEMS = 1250;
    localparam int          CALM_TAIL    = 150;
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [3:0]  CMD_TOP      = '1;
    localparam logic [32:0] REGION_BASE  = {1'b0, DATA_BASE};
    localparam logic [32:0] REGION_END   = REGION_BASE + 33'(DATA_BYTES);

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // Local copy of the data store, zero after reset
    logic [7:0] data_mem [DATA_BYTES];

    in_beat_t  access_queue[$];
    out_beat_t pending_results[$];
    int        total_items    = 0;
    int        accepted_count = 0;
    int        cycle_count    = 0;
    int        error_count    = 0;
    int        send_gap       = 0;
    int        stall_left     = 0;
    bit        in_taken       = 1'b0;

    mips_load_store_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Data store model
    // ------------------------------------------------------------------
    function automatic bit span_ok(logic [32:0] lo, logic [32:0] hi);
        logic [32:0] top;
        top = (REGION_END > 33'h1_0000_0000) ? 33'h1_0000_0000 : REGION_END;
        return lo >= REGION_BASE && lo <= hi && hi < top;
    endfunction

    function automatic logic [31:0] byte_at(logic [32:0] a);
        logic [32:0] idx;
        idx = a - REGION_BASE;
        return {24'b0, data_mem[int'(idx)]};
    endfunction

    function automatic void put_byte(logic [32:0] a, logic [7:0] v);
        logic [32:0] idx;
        idx = a - REGION_BASE;
        data_mem[int'(idx)] = v;
    endfunction

    // Apply one access to the model and return the result beat it gives
    function automatic out_beat_t predict_access(in_beat_t b);
        out_beat_t   r;
        logic [32:0] a;
        logic [31:0] v;
        logic [31:0] w;
        logic [31:0] mask;
        int          n;
        bit          ok;
        a  = {1'b0, b.address};
        v  = b.operand_value;
        w  = '0;
        ok = 1'b0;
        case (b.cmd)
            CMD_LB, CMD_LBU: begin
                if (span_ok(a, a)) begin
                    w = byte_at(a);
                    if (b.cmd == CMD_LB && w[7]) w[31:8] = '1;
                    ok = 1'b1;
                end
            end
            CMD_LH, CMD_LHU: begin
                if (!a[0] && span_ok(a, a + 33'd1)) begin
                    w = (byte_at(a) << 8) | byte_at(a + 33'd1);
                    if (b.cmd == CMD_LH && w[15]) w[31:16] = '1;
                    ok = 1'b1;
                end
            end
            CMD_LW: begin
                if (a[1:0] == 2'b00 && span_ok(a, a + 33'd3)) begin
                    w = (byte_at(a) << 24) | (byte_at(a + 33'd1) << 16) |
                        (byte_at(a + 33'd2) << 8) | byte_at(a + 33'd3);
                    ok = 1'b1;
                end
            end
            CMD_LWL: begin
                // Bytes from the address to the end of its word fill the top
                n = 4 - int'(a[1:0]);
                if (span_ok(a, a + 33'(n - 1))) begin
                    for (int i = 0; i < n; i++) w |= byte_at(a + 33'(i)) << (24 - 8 * i);
                    mask = (n == 4) ? 32'h0 : (32'hFFFF_FFFF >> (8 * n));
                    w |= v & mask;
                    ok = 1'b1;
                end
            end
            CMD_LWR: begin
                // Bytes from the start of the word to the address fill the bottom
                n = int'(a[1:0]) + 1;
                if (span_ok(a - 33'(n - 1), a)) begin
                    for (int i = 0; i < n; i++) w |= byte_at(a - 33'(i)) << (8 * i);
                    mask = (n == 4) ? 32'h0 : (32'hFFFF_FFFF << (8 * n));
                    w |= v & mask;
                    ok = 1'b1;
                end
            end
            CMD_SB: begin
                if (span_ok(a, a)) begin
                    put_byte(a, v[7:0]);
                    ok = 1'b1;
                end
            end
            CMD_SH: begin
                if (!a[0] && span_ok(a, a + 33'd1)) begin
                    put_byte(a, v[15:8]);
                    put_byte(a + 33'd1, v[7:0]);
                    ok = 1'b1;
                end
            end
            CMD_SW: begin
                if (a[1:0] == 2'b00 && span_ok(a, a + 33'd3)) begin
                    put_byte(a, v[31:24]);
                    put_byte(a + 33'd1, v[23:16]);
                    put_byte(a + 33'd2, v[15:8]);
                    put_byte(a + 33'd3, v[7:0]);
                    ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.read_data = ok ? w : '0;
        r.status    = ~ok;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_access(logic [3:0] cmd, logic [31:0] addr, logic [31:0] val);
        in_beat_t b;
        b.cmd           = cmd;
        b.address       = addr;
        b.operand_value = val;
        access_queue.push_back(b);
        total_items++;
    endtask

    task automatic build_directed;
        logic [31:0] base;
        logic [31:0] last_word;
        base      = DATA_BASE;
        last_word = REGION_END[31:0] - 32'd4;
        // Sign and zero extension on a known word
        push_access(CMD_SW,  base,          32'h80FF_7F01);
        push_access(CMD_LB,  base,          32'h0);
        push_access(CMD_LBU, base,          32'hFFFF_FFFF);
        push_access(CMD_LB,  base + 32'd2,  32'h0);
        push_access(CMD_LH,  base,          32'h0);
        push_access(CMD_LHU, base,          32'h0);
        push_access(CMD_LH,  base + 32'd2,  32'h0);
        push_access(CMD_LW,  base,          32'h0);
        // Partial word merges, including the full-word cases
        push_access(CMD_LWL, base + 32'd1,  32'hAABB_CCDD);
        push_access(CMD_LWR, base + 32'd2,  32'hAABB_CCDD);
        push_access(CMD_LWL, base,          32'h1122_3344);
        push_access(CMD_LWR, base + 32'd3,  32'h1122_3344);
        // Narrow stores, then read the word back
        push_access(CMD_SB,  base + 32'd5,  32'hFFFF_FF23);
        push_access(CMD_SH,  base + 32'd6,  32'h0000_BEEF);
        push_access(CMD_LW,  base + 32'd4,  32'h0);
        // Misaligned accesses; the failed store must leave the word intact
        push_access(CMD_LH,  base + 32'd1,  32'h0);
        push_access(CMD_SW,  base + 32'd1,  32'hDEAD_BEEF);
        push_access(CMD_LW,  base,          32'h0);
        // Region edges and addresses outside the data region
        push_access(CMD_SW,  last_word,     32'hCAFE_F00D);
        push_access(CMD_LWL, last_word + 32'd3, 32'h5555_5555);
        push_access(CMD_LB,  REGION_END[31:0], 32'h0);
        push_access(CMD_LWR, base - 32'd1,  32'h0);
        push_access(CMD_LWL, base - 32'd1,  32'h0);
        push_access(CMD_LB,  32'h0,         32'h0);
        push_access(CMD_LW,  32'hFFFF_FFFC, 32'h0);
        // Unknown commands
        push_access(CMD_SW + 4'd1, base,    32'hFFFF_FFFF);
        push_access(CMD_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic build_random;
        logic [3:0]  cmd;
        logic [31:0] addr;
        int          pick;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 6)
                cmd = 4'($urandom_range(int'(CMD_SW) + 1, int'(CMD_TOP)));
            else
                cmd = 4'($urandom_range(int'(CMD_LB), int'(CMD_SW)));
            // Keep most traffic in a small window so loads see earlier stores
            pick = $urandom_range(0, 99);
            if (pick < 65)
                addr = DATA_BASE + $urandom_range(0, 63);
            else if (pick < 78)
                addr = DATA_BASE + $urandom_range(0, DATA_BYTES - 1);
            else if (pick < 88)
                addr = DATA_BASE - 32'd8 + $urandom_range(0, 15);
            else if (pick < 96)
                addr = REGION_END[31:0] - 32'd8 + $urandom_range(0, 15);
            else
                addr = $urandom();
            // Mostly aligned halfword and word accesses
            if ($urandom_range(0, 3) != 0) begin
                if (cmd == CMD_LH || cmd == CMD_LHU || cmd == CMD_SH) addr[0] = 1'b0;
                if (cmd == CMD_LW || cmd == CMD_SW) addr[1:0] = 2'b00;
            end
            push_access(cmd, addr, $urandom());
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: present one beat at a time, with random gaps
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            in_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (access_queue.size() > 0) begin
                s_data  <= access_queue.pop_front();
                s_valid <= 1'b1;
                if (access_queue.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 5);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall in random bursts until the final stretch
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (access_queue.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input beats, check result beats
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_beat_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL mips_load_store_unit");
            $finish;
        end else if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_results.push_back(predict_access(s_data));
                accepted_count++;
                in_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", m_data.read_data, 32'h0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.read_data !== want.read_data)
                        report_mismatch("read_data", m_data.read_data, want.read_data);
                    if (m_data.status !== want.status)
                        report_mismatch("status", 32'(m_data.status), 32'(want.status));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < int'(DATA_BYTES); i++) data_mem[i] = 8'h00;
        build_directed();
        build_random();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait (accepted_count == total_items);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS mips_load_store_unit");
        end else begin
            $display("FAIL mips_load_store_unit");
        end
        $finish;
    end

endmodule : tb_mips_load_store_unit
`default_nettype wire

// ----- files.f -----
src/mls_pkg.sv
src/mls_decode.sv
src/mls_data_ram.sv
src/mls_format.sv
src/mips_load_store_unit.sv
tb/tb_mips_load_store_unit.sv
